// ===== design/sme_pkg.sv =====
// shared types and constants of the stack machine execute unit
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

  localparam int DATA_STACK_DEPTH_DEF   = 1024;
  localparam int RETURN_STACK_DEPTH_DEF = 256;
  localparam int PC_WIDTH_DEF           = 16;

  localparam int WORD_W = 64;
  localparam int LEN_W  = 17;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,
    OP_ADD   = 5'd1,
    OP_SUB   = 5'd2,
    OP_MUL   = 5'd3,
    OP_DIV   = 5'd4,
    OP_POP   = 5'd5,
    OP_PRINT = 5'd6,
    OP_JMP   = 5'd7,
    OP_CALL  = 5'd8,
    OP_RET   = 5'd9,
    OP_JZ    = 5'd10,
    OP_JNZ   = 5'd11,
    OP_INC   = 5'd12,
    OP_DEC   = 5'd13,
    OP_JEQ   = 5'd14,
    OP_JLT   = 5'd15,
    OP_JLTE  = 5'd16,
    OP_JGT   = 5'd17,
    OP_JGTE  = 5'd18,
    OP_NOP   = 5'd19,
    OP_BRK   = 5'd20,
    OP_HALT  = 5'd21
  } op_t;

  typedef enum logic [3:0] {
    ST_RUN       = 4'd0,
    ST_HALT      = 4'd1,
    ST_INVALID   = 4'd2,
    ST_UNDERFLOW = 4'd3,
    ST_OVERFLOW  = 4'd4,
    ST_RET_UNDER = 4'd5,
    ST_RET_OVER  = 4'd6,
    ST_PC_RANGE  = 4'd7,
    ST_DIV_ZERO  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_OPER2,
    S_WAIT,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ===== design/stack_machine_execute_unit_core.sv =====
// stack machine execute unit: top level with configuration register
// sequence: one-read instructions pass S_IDLE, S_EXEC and S_FIN; two-operand
//   add, sub and compare jumps add S_OPER2, mul and div also S_WAIT (64-step unit)
// one request at a time: a new request is taken only in S_IDLE, after the result
//   is handed to the output register; the data stack has a single read port
// reset (rst, synchronous): pc, depths, status, exit value cleared,
//   program_length set to 65536; stack contents are undefined until written
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_unit_core #(
  parameter int DATA_STACK_DEPTH   = sme_pkg::DATA_STACK_DEPTH_DEF,
  parameter int RETURN_STACK_DEPTH = sme_pkg::RETURN_STACK_DEPTH_DEF,
  parameter int PC_WIDTH           = sme_pkg::PC_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [16:0]  cfg_wdata,       // program_length
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,    // operation[4:0], operand[68:5]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [151:0]      m_axis_tdata,    // next_pc[15:0], status[19:16],
                                             // print_value[83:20], exit_value[147:84]
  output logic              m_axis_tuser     // print_valid
);
  import sme_pkg::*;

  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);

  logic [LEN_W-1:0]  program_length;
  logic              ds_we;
  logic [DAW-1:0]    ds_waddr, ds_raddr;
  logic [WORD_W-1:0] ds_wdata, ds_rdata;
  logic              rs_we;
  logic [RAW-1:0]    rs_waddr, rs_raddr;
  logic [PC_WIDTH-1:0] rs_wdata, rs_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [WORD_W-1:0] alu_a, alu_b;

  // program length register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 17'h10000;
    end else if (cfg_we) begin
      program_length <= cfg_wdata;
    end
  end

  sme_ctrl #(
    .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
    .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
    .PC_WIDTH           (PC_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .program_length (program_length),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .operation      (s_axis_tdata[4:0]),
    .operand        (s_axis_tdata[68:5]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (m_axis_tdata),
    .out_user       (m_axis_tuser),
    .ds_we          (ds_we),
    .ds_waddr       (ds_waddr),
    .ds_wdata       (ds_wdata),
    .ds_raddr       (ds_raddr),
    .ds_rdata       (ds_rdata),
    .rs_we          (rs_we),
    .rs_waddr       (rs_waddr),
    .rs_wdata       (rs_wdata),
    .rs_raddr       (rs_raddr),
    .rs_rdata       (rs_rdata),
    .alu_req        (alu_req),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_rsp        (alu_rsp)
  );

  sme_stack_mem #(
    .WIDTH (WORD_W),
    .DEPTH (DATA_STACK_DEPTH)
  ) u_data_stack (
    .clk   (clk),
    .we    (ds_we),
    .waddr (ds_waddr),
    .wdata (ds_wdata),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  sme_stack_mem #(
    .WIDTH (PC_WIDTH),
    .DEPTH (RETURN_STACK_DEPTH)
  ) u_return_stack (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  sme_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp)
  );

endmodule
`default_nettype wire

// ===== design/sme_stack_mem.sv =====
// stack storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module sme_stack_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/sme_alu.sv =====
// iterative multiply and signed divide, one bit per cycle on a shared adder
`timescale 1ns / 1ps
`default_nettype none
module sme_alu (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sme_pkg::alu_req_t             req,
  input  wire logic [sme_pkg::WORD_W-1:0]    a,
  input  wire logic [sme_pkg::WORD_W-1:0]    b,
  output sme_pkg::alu_rsp_t                  rsp
);
  import sme_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic              done;
  logic              is_div;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] opx;
  logic [WORD_W-1:0] opy;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   add_x;
  logic [WORD_W:0]   add_y;
  logic              add_c;
  logic [WORD_W:0]   sum;
  logic              take;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;

  // shared adder: trial subtract for divide, accumulate for multiply
  always_comb begin
    rem_sh = {acc, opx[WORD_W-1]};
    if (is_div) begin
      add_x = rem_sh;
      add_y = ~{1'b0, opy};
      add_c = 1'b1;
    end else begin
      add_x = {1'b0, acc};
      add_y = opy[0] ? {1'b0, opx} : '0;
      add_c = 1'b0;
    end
    sum  = add_x + add_y + {{WORD_W{1'b0}}, add_c};
    take = ~sum[WORD_W];
    mag_a = a[WORD_W-1] ? (~a + 1'b1) : a;
    mag_b = b[WORD_W-1] ? (~b + 1'b1) : b;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      acc    <= '0;
      neg    <= a[WORD_W-1] ^ b[WORD_W-1];
      opx    <= req.is_div ? mag_a : a;
      opy    <= req.is_div ? mag_b : b;
    end else if (busy) begin
      if (is_div) begin
        acc <= take ? sum[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        opx <= {opx[WORD_W-2:0], take};
      end else begin
        acc <= sum[WORD_W-1:0];
        opx <= {opx[WORD_W-2:0], 1'b0};
        opy <= {1'b0, opy[WORD_W-1:1]};
      end
    end
  end

  // result
  always_comb begin
    rsp.done = done;
    if (is_div) begin
      rsp.result = neg ? (~opx + 1'b1) : opx;
    end else begin
      rsp.result = acc;
    end
  end

`ifndef SYNTHESIS
  a_no_restart : assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("alu started while busy");
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("alu done while busy");
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("alu done without a run");
`endif

endmodule
`default_nettype wire

// ===== design/sme_ctrl.sv =====
// instruction sequencer: checks, stack access, pc update and result register
`timescale 1ns / 1ps
`default_nettype none
module sme_ctrl #(
  parameter int DATA_STACK_DEPTH   = sme_pkg::DATA_STACK_DEPTH_DEF,
  parameter int RETURN_STACK_DEPTH = sme_pkg::RETURN_STACK_DEPTH_DEF,
  parameter int PC_WIDTH           = sme_pkg::PC_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [sme_pkg::LEN_W-1:0]           program_length,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [4:0]                          operation,
  input  wire logic [sme_pkg::WORD_W-1:0]          operand,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [151:0]                             out_data,
  output logic                                     out_user,
  output logic                                     ds_we,
  output logic [$clog2(DATA_STACK_DEPTH)-1:0]      ds_waddr,
  output logic [sme_pkg::WORD_W-1:0]               ds_wdata,
  output logic [$clog2(DATA_STACK_DEPTH)-1:0]      ds_raddr,
  input  wire logic [sme_pkg::WORD_W-1:0]          ds_rdata,
  output logic                                     rs_we,
  output logic [$clog2(RETURN_STACK_DEPTH)-1:0]    rs_waddr,
  output logic [PC_WIDTH-1:0]                      rs_wdata,
  output logic [$clog2(RETURN_STACK_DEPTH)-1:0]    rs_raddr,
  input  wire logic [PC_WIDTH-1:0]                 rs_rdata,
  output sme_pkg::alu_req_t                        alu_req,
  output logic [sme_pkg::WORD_W-1:0]               alu_a,
  output logic [sme_pkg::WORD_W-1:0]               alu_b,
  input  wire sme_pkg::alu_rsp_t                   alu_rsp
);
  import sme_pkg::*;

  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int CW  = (PC_WIDTH + 2 > LEN_W) ? PC_WIDTH + 2 : LEN_W;

  seq_state_t        state, state_next;
  logic [PC_WIDTH-1:0] pc, pc_next;
  logic [DDW-1:0]    depth, depth_next;
  logic [RDW-1:0]    rdepth, rdepth_next;
  logic              stopped, stopped_next;
  status_t           held_status, status_next;
  logic [WORD_W-1:0] held_exit, exit_next;
  logic [4:0]        op_r;
  logic [WORD_W-1:0] arg_r;
  logic [WORD_W-1:0] top_r, top_next;
  logic              pv, pv_next;
  logic [WORD_W-1:0] pval, pval_next;
  logic              out_load;

  logic [CW-1:0]     pc_c, pc1, pc2, plen, limit;
  logic              arg_big;
  logic [DDW-1:0]    depth_m1, depth_m2;
  logic [RDW-1:0]    rdepth_m1;
  op_t               op_e;

  // address arithmetic in a width that holds every limit
  always_comb begin
    pc_c      = CW'(pc);
    pc1       = pc_c + CW'(1);
    pc2       = pc_c + CW'(2);
    plen      = CW'(program_length);
    limit     = {{(CW-PC_WIDTH-1){1'b0}}, 1'b1, {PC_WIDTH{1'b0}}};
    arg_big   = |arg_r[WORD_W-1:PC_WIDTH];
    depth_m1  = depth - DDW'(1);
    depth_m2  = depth - DDW'(2);
    rdepth_m1 = rdepth - RDW'(1);
    op_e      = op_t'(op_r);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pc          <= '0;
      depth       <= '0;
      rdepth      <= '0;
      stopped     <= 1'b0;
      held_status <= ST_RUN;
      held_exit   <= '0;
    end else begin
      state       <= state_next;
      pc          <= pc_next;
      depth       <= depth_next;
      rdepth      <= rdepth_next;
      stopped     <= stopped_next;
      held_status <= status_next;
      held_exit   <= exit_next;
    end
  end

  // per-instruction working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= operation;
      arg_r <= operand;
    end
    top_r <= top_next;
    pv    <= pv_next;
    pval  <= pval_next;
  end

  // next state and datapath control
  always_comb begin
    logic    flt;
    logic    take;
    status_t code;
    flt          = 1'b0;
    take         = 1'b0;
    code         = ST_RUN;
    state_next   = state;
    pc_next      = pc;
    depth_next   = depth;
    rdepth_next  = rdepth;
    stopped_next = stopped;
    status_next  = held_status;
    exit_next    = held_exit;
    top_next     = top_r;
    pv_next      = pv;
    pval_next    = pval;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    ds_we        = 1'b0;
    ds_waddr     = depth_m2[DAW-1:0];
    ds_wdata     = alu_rsp.result;
    ds_raddr     = depth_m1[DAW-1:0];
    rs_we        = 1'b0;
    rs_waddr     = rdepth[RAW-1:0];
    rs_wdata     = pc2[PC_WIDTH-1:0];
    rs_raddr     = rdepth_m1[RAW-1:0];
    alu_req      = '0;
    alu_a        = top_r;
    alu_b        = ds_rdata;

    unique case (state)
      // wait for a request; top of each stack is being read meanwhile
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pv_next    = 1'b0;
          pval_next  = '0;
          state_next = S_EXEC;
        end
      end

      // first decode and single-read instructions
      S_EXEC: begin
        state_next = S_FIN;
        ds_raddr   = depth_m2[DAW-1:0];
        priority if (stopped) begin
          state_next = S_FIN;
        end else if (pc_c >= plen) begin
          flt = 1'b1; code = ST_PC_RANGE;
        end else if (op_r > OP_HALT) begin
          flt = 1'b1; code = ST_INVALID;
        end else if ((op_e == OP_PUSH || op_e == OP_JMP || op_e == OP_CALL ||
                      op_e == OP_JZ || op_e == OP_JNZ || op_e == OP_JEQ ||
                      op_e == OP_JLT || op_e == OP_JLTE || op_e == OP_JGT ||
                      op_e == OP_JGTE) && pc1 >= plen) begin
          flt = 1'b1; code = ST_PC_RANGE;
        end else begin
          unique case (op_e)
            OP_PUSH: begin
              if (depth >= DDW'(DATA_STACK_DEPTH)) begin
                flt = 1'b1; code = ST_OVERFLOW;
              end else if (pc2 >= limit) begin
                flt = 1'b1; code = ST_PC_RANGE;
              end else begin
                ds_we      = 1'b1;
                ds_waddr   = depth[DAW-1:0];
                ds_wdata   = arg_r;
                depth_next = depth + DDW'(1);
                pc_next    = pc2[PC_WIDTH-1:0];
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_JEQ, OP_JLT, OP_JLTE, OP_JGT, OP_JGTE: begin
              if (depth < DDW'(2)) begin
                flt = 1'b1; code = ST_UNDERFLOW;
              end else begin
                top_next   = ds_rdata;
                state_next = S_OPER2;
              end
            end
            OP_POP, OP_PRINT, OP_INC, OP_DEC: begin
              if (depth == '0) begin
                flt = 1'b1; code = ST_UNDERFLOW;
              end else if (pc1 >= limit) begin
                flt = 1'b1; code = ST_PC_RANGE;
              end else begin
                pc_next  = pc1[PC_WIDTH-1:0];
                ds_waddr = depth_m1[DAW-1:0];
                if (op_e == OP_POP) begin
                  depth_next = depth_m1;
                end else if (op_e == OP_PRINT) begin
                  pv_next   = 1'b1;
                  pval_next = ds_rdata;
                end else if (op_e == OP_INC) begin
                  ds_we    = 1'b1;
                  ds_wdata = ds_rdata + 1'b1;
                end else begin
                  ds_we    = 1'b1;
                  ds_wdata = ds_rdata - 1'b1;
                end
              end
            end
            OP_JMP: begin
              if (arg_big) begin
                flt = 1'b1; code = ST_PC_RANGE;
              end else begin
                pc_next = arg_r[PC_WIDTH-1:0];
              end
            end
            OP_CALL: begin
              if (rdepth >= RDW'(RETURN_STACK_DEPTH)) begin
                flt = 1'b1; code = ST_RET_OVER;
              end else if (pc2 >= limit || arg_big) begin
                flt = 1'b1; code = ST_PC_RANGE;
              end else begin
                rs_we       = 1'b1;
                rdepth_next = rdepth + RDW'(1);
                pc_next     = arg_r[PC_WIDTH-1:0];
              end
            end
            OP_RET: begin
              if (rdepth == '0) begin
                flt = 1'b1; code = ST_RET_UNDER;
              end else begin
                rdepth_next = rdepth_m1;
                pc_next     = rs_rdata;
              end
            end
            OP_JZ, OP_JNZ: begin
              take = ((op_e == OP_JZ) == (ds_rdata == '0));
              if (depth == '0) begin
                flt = 1'b1; code = ST_UNDERFLOW;
              end else if (take ? arg_big : (pc2 >= limit)) begin
                flt = 1'b1; code = ST_PC_RANGE;
              end else begin
                pc_next = take ? arg_r[PC_WIDTH-1:0] : pc2[PC_WIDTH-1:0];
              end
            end
            OP_NOP: begin
              if (pc1 >= limit) begin
                flt = 1'b1; code = ST_PC_RANGE;
              end else begin
                pc_next = pc1[PC_WIDTH-1:0];
              end
            end
            OP_BRK, OP_HALT: begin
              if (depth == '0) begin
                flt = 1'b1; code = ST_UNDERFLOW;
              end else begin
                exit_next = ds_rdata;
                flt = 1'b1; code = ST_HALT;
              end
            end
            default: begin
              flt = 1'b1; code = ST_INVALID;
            end
          endcase
        end
      end

      // second operand is on the read port
      S_OPER2: begin
        state_next = S_FIN;
        if (op_e == OP_ADD || op_e == OP_SUB || op_e == OP_MUL || op_e == OP_DIV) begin
          if (op_e == OP_DIV && ds_rdata == '0) begin
            flt = 1'b1; code = ST_DIV_ZERO;
          end else if (pc1 >= limit) begin
            flt = 1'b1; code = ST_PC_RANGE;
          end else if (op_e == OP_ADD || op_e == OP_SUB) begin
            ds_we      = 1'b1;
            ds_wdata   = (op_e == OP_ADD) ? (top_r + ds_rdata) : (top_r - ds_rdata);
            depth_next = depth_m1;
            pc_next    = pc1[PC_WIDTH-1:0];
          end else begin
            alu_req.start  = 1'b1;
            alu_req.is_div = (op_e == OP_DIV);
            state_next     = S_WAIT;
          end
        end else begin
          // compare jumps: top is b, the word below is a
          priority case (op_e)
            OP_JEQ:  take = ds_rdata == top_r;
            OP_JLT:  take = ds_rdata <  top_r;
            OP_JLTE: take = ds_rdata <= top_r;
            OP_JGT:  take = ds_rdata >  top_r;
            default: take = ds_rdata >= top_r;
          endcase
          if (take ? arg_big : (pc2 >= limit)) begin
            flt = 1'b1; code = ST_PC_RANGE;
          end else begin
            pc_next    = take ? arg_r[PC_WIDTH-1:0] : pc2[PC_WIDTH-1:0];
            depth_next = (op_e == OP_JEQ) ? depth_m1 : depth_m2;
          end
        end
      end

      // multiply or divide in flight
      S_WAIT: begin
        if (alu_rsp.done) begin
          ds_we      = 1'b1;
          depth_next = depth_m1;
          pc_next    = pc1[PC_WIDTH-1:0];
          state_next = S_FIN;
        end
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (flt) begin
      stopped_next = 1'b1;
      status_next  = code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {4'b0, held_exit, pval, held_status, 16'(pc)};
      out_user <= pv;
    end
  end

`ifndef SYNTHESIS
  a_stop_status : assert property (@(posedge clk) disable iff (rst)
    stopped == (held_status != ST_RUN)) else $error("stop flag and status disagree");
  a_depth_range : assert property (@(posedge clk) disable iff (rst)
    depth <= DDW'(DATA_STACK_DEPTH)) else $error("data stack depth out of range");
  a_rdepth_range : assert property (@(posedge clk) disable iff (rst)
    rdepth <= RDW'(RETURN_STACK_DEPTH)) else $error("return depth out of range");
  a_print_running : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_user) |-> (out_data[19:16] == ST_RUN))
    else $error("print reported with a stopped status");
  a_alu_from_oper2 : assert property (@(posedge clk) disable iff (rst)
    alu_req.start |=> (state == S_WAIT)) else $error("alu started outside operand step");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the stack machine execute unit
`timescale 1ns / 1ps
module tb;
  import sme_pkg::*;

  typedef struct {
    logic [15:0] next_pc;
    status_t     status;
    logic        print_valid;
    logic [63:0] print_value;
    logic [63:0] exit_value;
  } outcome_t;

  localparam logic [63:0] MIN_WORD = 64'h8000_0000_0000_0000;
  localparam int unsigned PC_SPAN = 65536;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [16:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // operation[4:0], operand[68:5]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;        // next_pc, status, print_value, exit_value
  logic         m_axis_tuser;        // print_valid

  stack_machine_execute_unit_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // machine state mirror
  logic [63:0] mir_stack [DATA_STACK_DEPTH_DEF];
  logic [15:0] mir_ret [RETURN_STACK_DEPTH_DEF];
  int unsigned mir_pc = 0;
  int unsigned mir_depth = 0;
  int unsigned mir_rdepth = 0;
  bit          mir_stopped = 0;
  status_t     mir_status = ST_RUN;
  logic [63:0] mir_exit = '0;
  int unsigned mir_len = PC_SPAN;

  logic [71:0] request_q [$];
  outcome_t    outcome_q [$];
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  bit          in_acc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 0;

  // quiet window with no idling on either side
  wire calm = (sent_cnt >= 500) && (sent_cnt < 700);

  initial forever #5 clk = ~clk;

  // executes one instruction on the mirror state
  function automatic outcome_t execute_step(logic [4:0] op, logic [63:0] arg);
    outcome_t    r;
    int unsigned pc, nxt, d;
    status_t     st;
    bit          fault, take, uses;
    logic [63:0] a, b, ma, mb, q;
    pc = mir_pc; nxt = pc + 1; d = mir_depth;
    st = ST_RUN; fault = 0;
    r.print_valid = 0; r.print_value = '0;
    uses = (op == OP_PUSH) || (op == OP_JMP) || (op == OP_CALL) || (op == OP_JZ) ||
           (op == OP_JNZ) || (op >= OP_JEQ && op <= OP_JGTE);
    if (!mir_stopped) begin
      if (pc >= mir_len) begin
        st = ST_PC_RANGE; fault = 1;
      end else if (op > OP_HALT) begin
        st = ST_INVALID; fault = 1;
      end else if (uses && pc + 1 >= mir_len) begin
        st = ST_PC_RANGE; fault = 1;
      end else begin
        case (op)
          OP_PUSH: begin
            nxt = pc + 2;
            if (d >= DATA_STACK_DEPTH_DEF) begin st = ST_OVERFLOW; fault = 1; end
            else if (nxt >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
            else begin mir_stack[d] = arg; mir_depth = d + 1; end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (d < 2) begin st = ST_UNDERFLOW; fault = 1; end
            else begin
              a = mir_stack[d-1]; b = mir_stack[d-2];
              if (op == OP_DIV && b == 0) begin st = ST_DIV_ZERO; fault = 1; end
              else if (nxt >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
              else begin
                if (op == OP_ADD) q = a + b;
                else if (op == OP_SUB) q = a - b;
                else if (op == OP_MUL) q = a * b;
                else begin
                  // signed divide through magnitudes, truncating toward zero
                  ma = a[63] ? -a : a;
                  mb = b[63] ? -b : b;
                  q = ma / mb;
                  if (a[63] != b[63]) q = -q;
                end
                mir_stack[d-2] = q; mir_depth = d - 1;
              end
            end
          end
          OP_POP, OP_PRINT, OP_INC, OP_DEC: begin
            if (d == 0) begin st = ST_UNDERFLOW; fault = 1; end
            else if (nxt >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
            else if (op == OP_POP) mir_depth = d - 1;
            else if (op == OP_PRINT) begin
              r.print_valid = 1; r.print_value = mir_stack[d-1];
            end
            else if (op == OP_INC) mir_stack[d-1] = mir_stack[d-1] + 1;
            else mir_stack[d-1] = mir_stack[d-1] - 1;
          end
          OP_JMP: begin
            if (arg >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
            else nxt = arg;
          end
          OP_CALL: begin
            if (mir_rdepth >= RETURN_STACK_DEPTH_DEF) begin st = ST_RET_OVER; fault = 1; end
            else if (pc + 2 >= PC_SPAN || arg >= PC_SPAN) begin
              st = ST_PC_RANGE; fault = 1;
            end else begin
              mir_ret[mir_rdepth] = 16'(pc + 2);
              mir_rdepth++;
              nxt = arg;
            end
          end
          OP_RET: begin
            if (mir_rdepth == 0) begin st = ST_RET_UNDER; fault = 1; end
            else begin mir_rdepth--; nxt = mir_ret[mir_rdepth]; end
          end
          OP_JZ, OP_JNZ: begin
            if (d == 0) begin st = ST_UNDERFLOW; fault = 1; end
            else begin
              take = ((op == OP_JZ) == (mir_stack[d-1] == 0));
              if (take && arg >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
              else nxt = take ? int'(arg) : pc + 2;
              if (!fault && nxt >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
            end
          end
          OP_JEQ, OP_JLT, OP_JLTE, OP_JGT, OP_JGTE: begin
            if (d < 2) begin st = ST_UNDERFLOW; fault = 1; end
            else begin
              b = mir_stack[d-1]; a = mir_stack[d-2];
              case (op)
                OP_JEQ:  take = a == b;
                OP_JLT:  take = a < b;
                OP_JLTE: take = a <= b;
                OP_JGT:  take = a > b;
                default: take = a >= b;
              endcase
              if (take && arg >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
              else nxt = take ? int'(arg) : pc + 2;
              if (!fault && nxt >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
              if (!fault) mir_depth = (op == OP_JEQ) ? d - 1 : d - 2;
            end
          end
          OP_NOP: begin
            if (nxt >= PC_SPAN) begin st = ST_PC_RANGE; fault = 1; end
          end
          default: begin
            // halt and break latch the top of stack
            if (d == 0) begin st = ST_UNDERFLOW; fault = 1; end
            else begin mir_exit = mir_stack[d-1]; st = ST_HALT; fault = 1; end
          end
        endcase
      end
      if (fault) begin
        mir_status = st; mir_stopped = 1;
      end else mir_pc = nxt % PC_SPAN;
    end
    r.next_pc = 16'(mir_pc);
    r.status = mir_status;
    r.exit_value = mir_exit;
    return r;
  endfunction

  task automatic queue_request(logic [4:0] op, logic [63:0] arg);
    outcome_q.push_back(execute_step(op, arg));
    request_q.push_back({3'b000, arg, op});
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 3));
      1: case ($urandom_range(0, 3))
           0: return '0;
           1: return '1;
           2: return MIN_WORD;
           default: return ~MIN_WORD;
         endcase
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one random instruction that keeps the machine running
  task automatic queue_random();
    logic [4:0]  op;
    logic [63:0] arg;
    int unsigned k, d, rd;
    d = mir_depth; rd = mir_rdepth;
    arg = 64'($urandom_range(0, mir_len - 9));
    op = OP_NOP;
    k = $urandom_range(0, 99);
    if (mir_pc + 8 >= mir_len) op = OP_JMP;
    else if (k < 25) op = OP_PUSH;
    else if (k < 30) op = ($urandom_range(0, 1) != 0) ? OP_ADD : OP_SUB;
    else if (k < 34) op = OP_MUL;
    else if (k < 37) op = OP_DIV;
    else if (k < 43) op = 5'(OP_POP + $urandom_range(0, 1) + 7 * $urandom_range(0, 1));
    else if (k < 50) op = OP_JMP;
    else if (k < 55) op = (rd < RETURN_STACK_DEPTH_DEF) ? OP_CALL : OP_NOP;
    else if (k < 60) op = (rd > 0 && mir_ret[rd-1] + 8 < mir_len) ? OP_RET : OP_NOP;
    else if (k < 70) op = ($urandom_range(0, 1) != 0) ? OP_JZ : OP_JNZ;
    else if (k < 85) op = 5'(OP_JEQ + $urandom_range(0, 4));
    // fall back to a push when the stack is too shallow or a divide would be by zero
    if ((op >= OP_ADD && op <= OP_DIV) || (op >= OP_JEQ && op <= OP_JGTE)) begin
      if (d < 2 || (op == OP_DIV && mir_stack[d-2] == 0)) op = OP_PUSH;
    end
    if (op == OP_POP || op == OP_PRINT || op == OP_INC || op == OP_DEC ||
        op == OP_JZ || op == OP_JNZ) begin
      if (d == 0) op = OP_PUSH;
    end
    if (op == OP_PUSH) begin
      if (d >= 60) op = OP_POP;
      else arg = pick_value();
    end
    queue_request(op, arg);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_length(int unsigned len);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1; cfg_wdata = 17'(len);
    @(negedge clk);
    cfg_we = 1'b0;
    mir_len = len;
  endtask

  // request driver
  always @(posedge clk) in_acc <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        void'(request_q.pop_front());
        sent_cnt++;
      end
      if (!(s_axis_tvalid && !in_acc)) begin
        if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= request_q[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side ready, with one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent_cnt >= 300) begin
      hold_done = 1;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = outcome_q.pop_front();
        if (m_axis_tdata[15:0] !== e.next_pc || m_axis_tdata[19:16] !== e.status ||
            m_axis_tdata[83:20] !== e.print_value || m_axis_tdata[147:84] !== e.exit_value ||
            m_axis_tuser !== e.print_valid) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp pc %h st %0d pv %b pval %h exit %h, got pc %h st %0d pv %b pval %h exit %h",
                     e.next_pc, e.status, e.print_valid, e.print_value, e.exit_value,
                     m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tuser,
                     m_axis_tdata[83:20], m_axis_tdata[147:84]);
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_length(PC_SPAN);

    // directed: extremes, divide overflow, wraps, zero tests, call and return, equal and less-than jumps
    queue_request(OP_PUSH, '1);
    queue_request(OP_PUSH, MIN_WORD);
    queue_request(OP_DIV, 64'd0);
    queue_request(OP_PRINT, 64'd0);
    queue_request(OP_INC, 64'd0);
    queue_request(OP_DEC, 64'd0);
    queue_request(OP_PUSH, 64'd0);
    queue_request(OP_DEC, 64'd0);
    queue_request(OP_ADD, 64'd0);
    queue_request(OP_PUSH, 64'd7);
    queue_request(OP_SUB, 64'd0);
    queue_request(OP_PUSH, 64'd3);
    queue_request(OP_MUL, 64'd0);
    queue_request(OP_JZ, 64'd40);
    queue_request(OP_JNZ, 64'd60);
    queue_request(OP_CALL, 64'd100);
    queue_request(OP_NOP, 64'd0);
    queue_request(OP_RET, 64'd0);
    queue_request(OP_PUSH, 64'd5);
    queue_request(OP_PUSH, 64'd5);
    queue_request(OP_JEQ, 64'd200);
    queue_request(OP_JLT, 64'd210);
    queue_request(OP_PUSH, 64'd0);
    queue_request(OP_JZ, 64'd300);
    queue_request(OP_POP, 64'd0);

    repeat (450) queue_random();
    queue_request(OP_JMP, 64'd0);
    write_length($urandom_range(64, PC_SPAN - 1));
    repeat (350) queue_random();
    queue_request(OP_JMP, 64'd0);
    write_length(16);
    repeat (300) queue_random();
    queue_request(OP_JMP, 64'd0);
    write_length(PC_SPAN);
    repeat (100) queue_random();

    // one terminating condition per run
    case ($urandom_range(0, 6))
      0: begin queue_request(OP_PUSH, pick_value()); queue_request(OP_HALT, '0); end
      1: begin queue_request(OP_PUSH, pick_value()); queue_request(OP_BRK, '0); end
      2: queue_request(5'($urandom_range(OP_HALT + 1, 31)), {$urandom, $urandom});
      3: begin
        queue_request(OP_PUSH, '0);
        queue_request(OP_PUSH, pick_value());
        queue_request(OP_DIV, '0);
      end
      4: begin
        queue_request(OP_NOP, '0);
        write_length(1);
        queue_request(OP_NOP, '0);
      end
      5: begin
        // jump past the program end is taken, the next step faults
        queue_request(OP_JMP, 64'd0);
        write_length(20);
        queue_request(OP_JMP, 64'($urandom_range(20, PC_SPAN - 1)));
        queue_request(OP_NOP, '0);
      end
      default: begin
        repeat (mir_depth) queue_request(OP_POP, '0);
        queue_request(OP_POP, '0);
      end
    endcase
    // stopped machine ignores everything
    repeat (6) queue_request(5'($urandom_range(0, 31)), {$urandom, $urandom});

    while (request_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
